// ----- rtl/core/adcsaw_pkg.sv -----
package adcsaw_pkg;

    // Default geometry and coefficient format
    localparam int COLUMNS_DEF    = 12;
    localparam int NODES_DEF      = 4;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int SEL_COUNT      = 6;
    localparam int STAGES         = 10;

    // Item kinds
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Coefficient selects, one bank each
    localparam logic [2:0] SEL_GAIN      = 3'd0;
    localparam logic [2:0] SEL_OFFSET    = 3'd1;
    localparam logic [2:0] SEL_SAW       = 3'd2;
    localparam logic [2:0] SEL_STEP      = 3'd3;
    localparam logic [2:0] SEL_DARK_LOW  = 3'd4;
    localparam logic [2:0] SEL_DARK_HIGH = 3'd5;

    // Status codes
    localparam logic [3:0] ST_OK     = 4'd0;
    localparam logic [3:0] ST_OVER1  = 4'd1;
    localparam logic [3:0] ST_OVER2  = 4'd2;
    localparam logic [3:0] ST_OVER3  = 4'd3;
    localparam logic [3:0] ST_OVER4  = 4'd4;
    localparam logic [3:0] ST_UNDER1 = 4'd5;
    localparam logic [3:0] ST_UNDER2 = 4'd6;
    localparam logic [3:0] ST_UNDER3 = 4'd7;
    localparam logic [3:0] ST_UNDER4 = 4'd8;

    // Register index (address bit 2)
    localparam logic REG_BYPASS   = 1'b0;
    localparam logic REG_PEDESTAL = 1'b1;
    localparam logic [11:0] PEDESTAL_RESET = 12'd100;

    // x/25 as (x*RECIP_25)>>RECIP_SHIFT, exact for x < 2^16
    localparam logic [17:0] RECIP_25    = 18'd167773;
    localparam int          RECIP_SHIFT = 22;

    // One queued item after classification
    typedef struct packed {
        logic        kind;
        logic [2:0]  sel;
        logic [31:0] coef;
        logic [7:0]  hb;
        logic [7:0]  lb;
        logic        low_gain;
    } item_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic        bypass_dark;
        logic [11:0] dark_pedestal;
    } cfg_t;

endpackage

// ----- rtl/core/adcsaw_queue.sv -----
module adcsaw_queue
    import adcsaw_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = buf_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/core/adcsaw_front.sv -----
module adcsaw_front
    import adcsaw_pkg::*;
#(
    parameter int NODES   = NODES_DEF,
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROW_W   = 6
) (
    input  logic             s_tvalid,
    output logic             s_tready,
    // node, column, full_frame, coef_select, coef_value, high_byte, low_byte, low_gain
    input  logic [63:0]      s_tdata,
    // opcode
    input  logic             s_tuser,
    input  logic             q_full,
    input  logic             clearing,
    output logic             push,
    output logic [ROW_W-1:0] push_row,
    output item_t            push_item
);
    logic [1:0] node, node_sat;
    logic [4:0] column;
    logic [5:0] slot, slot_sat;

    assign s_tready = !q_full && !clearing;
    assign push     = s_tvalid && s_tready;

    // Row address: saturate node and slot into the store
    always_comb begin
        node     = s_tdata[1:0];
        column   = s_tdata[6:2];
        slot     = s_tdata[7] ? {1'b0, column} : {2'b0, column[4:1]};
        node_sat = (int'(node) >= NODES) ? 2'(NODES - 1) : node;
        slot_sat = (int'(slot) >= COLUMNS) ? 6'(COLUMNS - 1) : slot;
        push_row = ROW_W'(int'(node_sat) * COLUMNS + int'(slot_sat));
    end

    // Classify and unpack
    always_comb begin
        push_item.kind     = (s_tuser == OP_CONVERT) ? OP_CONVERT : OP_WRITE;
        push_item.sel      = s_tdata[10:8];
        push_item.coef     = s_tdata[42:11];
        push_item.hb       = s_tdata[50:43];
        push_item.lb       = s_tdata[58:51];
        push_item.low_gain = s_tdata[59];
    end

endmodule

// ----- rtl/core/adcsaw_back.sv -----
module adcsaw_back
    import adcsaw_pkg::*;
#(
    parameter int NODES          = NODES_DEF,
    parameter int COLUMNS        = COLUMNS_DEF,
    parameter int COEF_FRAC_BITS = FRAC_BITS_DEF,
    parameter int ROW_W          = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             q_empty,
    input  logic [ROW_W-1:0] q_row,
    input  item_t            q_item,
    output logic             q_pop,
    output logic             clearing,
    output logic             m_tvalid,
    input  logic             m_tready,
    // value[13:0], status[17:14], zero fill
    output logic [23:0]      m_tdata
);
    localparam int ROWS = NODES * COLUMNS;
    localparam int F    = COEF_FRAC_BITS;
    localparam logic [31:0]        ONE   = 32'(64'(1) << F);
    localparam logic signed [42:0] BIAS1 = 43'((64'(1) << F) - 1);
    localparam logic signed [60:0] BIAS2 = 61'((64'(1) << (F + 8)) - 1);
    localparam logic signed [31:0] BIASD = 32'((64'(1) << F) - 1);

    logic en, pop_conv;
    logic clr_reg;
    logic [ROW_W-1:0] clr_row_reg;
    logic [STAGES:1] vld_reg;
    logic m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    // Coefficient banks
    logic [31:0] rd_reg [SEL_COUNT];
    logic [SEL_COUNT-1:0] we;
    logic [ROW_W-1:0] wa;
    logic [31:0] wd [SEL_COUNT];

    assign en       = !m_tvalid_reg || m_tready;
    assign q_pop    = en && !q_empty && !clr_reg;
    assign pop_conv = q_pop && (q_item.kind == OP_CONVERT);
    assign clearing = clr_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign wa       = clr_reg ? clr_row_reg : q_row;

    // Clearing sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_row_reg <= '0;
        end else if (clr_reg) begin
            if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                clr_reg <= 1'b0;
            end
            clr_row_reg <= clr_row_reg + 1'b1;
        end
    end

    for (genvar b = 0; b < SEL_COUNT; b++) begin : g_bank
        logic [31:0] mem [ROWS];
        always_comb begin
            we[b] = clr_reg || (q_pop && q_item.kind == OP_WRITE && q_item.sel == 3'(b));
            if (clr_reg) begin
                wd[b] = (b == int'(SEL_GAIN)) ? ONE : '0;
            end else begin
                wd[b] = q_item.coef;
            end
        end
        always_ff @(posedge aclk) begin
            if (we[b]) begin
                mem[wa] <= wd[b];
            end
            if (pop_conv) begin
                rd_reg[b] <= mem[q_row];
            end
        end
    end

    // Side data shift lines
    logic [7:0]  hb_pipe_reg [1:STAGES];
    logic [7:0]  lb_pipe_reg [1:STAGES];
    logic        lg1_reg;
    logic [31:0] dark_pipe_reg [2:STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            hb_pipe_reg[1] <= q_item.hb;
            lb_pipe_reg[1] <= q_item.lb;
            lg1_reg        <= q_item.low_gain;
            dark_pipe_reg[2] <= lg1_reg ? rd_reg[SEL_DARK_LOW] : rd_reg[SEL_DARK_HIGH];
            for (int i = 2; i <= STAGES; i++) begin
                hb_pipe_reg[i] <= hb_pipe_reg[i-1];
                lb_pipe_reg[i] <= lb_pipe_reg[i-1];
            end
            for (int i = 3; i <= STAGES; i++) begin
                dark_pipe_reg[i] <= dark_pipe_reg[i-1];
            end
        end
    end

    // Stage 2: gain * hb
    logic signed [40:0] p2_reg, p2_next;
    logic signed [31:0] off2_reg, step2_reg, saw2_reg;
    assign p2_next = $signed(rd_reg[SEL_GAIN]) * $signed({1'b0, hb_pipe_reg[1]});

    // Stage 3: o1 = gain*hb + offset (+ step for hb >= 128)
    logic signed [42:0] o1_3_reg, o1_3_next;
    logic signed [31:0] saw3_reg, step_term;
    assign step_term = hb_pipe_reg[2][7] ? step2_reg : '0;
    assign o1_3_next = p2_reg + off2_reg + step_term;

    // Stage 4: l1 from truncated o1, sawtooth operands
    logic signed [42:0] o1b, t1, o1_4_reg;
    logic signed [43:0] l1;
    logic signed [16:0] l1s;
    logic signed [17:0] m4_reg, m4_next;
    logic signed [9:0]  k4_reg, k4_next;
    logic signed [31:0] saw4_reg;
    always_comb begin
        o1b = o1_3_reg[42] ? o1_3_reg + BIAS1 : o1_3_reg;
        t1  = o1b >>> F;
        l1  = t1 + $signed({1'b0, lb_pipe_reg[3]});
        if (l1 > 44'sd65535) begin
            l1s = 17'sd65535;
        end else if (l1 < -44'sd65536) begin
            l1s = -17'sd65536;
        end else begin
            l1s = l1[16:0];
        end
        m4_next = l1s - 18'sd127;
        k4_next = 10'sd400 - $signed({2'b0, hb_pipe_reg[3]});
    end

    // Stage 5: saw * (l1-127)
    logic signed [49:0] q5_reg, q5_next;
    logic signed [42:0] o1_5_reg;
    logic signed [9:0]  k5_reg;
    assign q5_next = saw4_reg * m4_reg;

    // Stage 6: times (400-hb); o1*6400 by shifts
    logic signed [59:0] s6_reg, s6_next;
    logic signed [55:0] o1w, o64_6_reg, o64_6_next;
    always_comb begin
        o1w        = o1_5_reg;
        s6_next    = q5_reg * k5_reg;
        o64_6_next = (o1w <<< 12) + (o1w <<< 11) + (o1w <<< 8);
    end

    // Stage 7: full numerator
    logic signed [60:0] num7_reg, num7_next;
    assign num7_next = s6_reg + o64_6_reg;

    // Stage 8: divide by 2^(F+8) toward zero, saturate magnitude
    logic signed [60:0] nb, a8, a8abs;
    logic [15:0] mag8_reg, mag8_next;
    logic        neg8_reg;
    always_comb begin
        nb    = num7_reg[60] ? num7_reg + BIAS2 : num7_reg;
        a8    = nb >>> (F + 8);
        a8abs = a8[60] ? -a8 : a8;
        mag8_next = (a8abs > 61'sd65535) ? 16'hFFFF : a8abs[15:0];
    end

    // Stage 9: divide magnitude by 25
    logic [33:0] prod9;
    logic [11:0] qd9_reg;
    logic        neg9_reg;
    assign prod9 = 34'(mag8_reg) * 34'(RECIP_25);

    // Stage 10: clamp, plausibility grading, base value
    logic signed [12:0] t2;
    logic signed [13:0] lbs, lbpc;
    logic signed [9:0]  qerr;
    logic [7:0]  lbc, lbp, hb10, lb10;
    logic [3:0]  st10_next, st10_reg;
    logic [11:0] v10_next, v10_reg;
    always_comb begin
        hb10 = hb_pipe_reg[9];
        lb10 = lb_pipe_reg[9];
        t2   = neg9_reg ? -$signed({1'b0, qd9_reg}) : $signed({1'b0, qd9_reg});
        lbs  = $signed({6'b0, lb10}) + t2;
        if (lbs < 14'sd0) begin
            lbc = 8'd0;
        end else if (lbs > 14'sd255) begin
            lbc = 8'd255;
        end else begin
            lbc = lbs[7:0];
        end
        lbp  = {hb10[3:0], 4'h7};
        lbpc = $signed({6'b0, lbp}) - t2;
        qerr = $signed({2'b0, lbp}) - $signed({2'b0, lbc});
        if (lbpc > 14'sd275) begin
            st10_next = ST_OVER1;
        end else if (lbpc > 14'sd255 && qerr > 10'sd28) begin
            st10_next = ST_OVER2;
        end else if (lbpc > 14'sd191 && qerr > 10'sd52) begin
            st10_next = ST_OVER3;
        end else if (qerr > 10'sd96) begin
            st10_next = ST_OVER4;
        end else if (lbpc < -14'sd20) begin
            st10_next = ST_UNDER1;
        end else if (lbpc < 14'sd0 && qerr < -10'sd28) begin
            st10_next = ST_UNDER2;
        end else if (lbpc < 14'sd64 && qerr < -10'sd52) begin
            st10_next = ST_UNDER3;
        end else if (qerr < -10'sd96) begin
            st10_next = ST_UNDER4;
        end else begin
            st10_next = ST_OK;
        end
        v10_next = (st10_next != ST_OK) ? {hb10, 4'h7} : {hb10[7:4], lbc};
    end

    // Output: dark subtraction, pedestal, saturation (all skipped in bypass)
    logic signed [31:0] dkb, dt;
    logic signed [34:0] res;
    logic [13:0] val_out;
    always_comb begin
        dkb = dark_pipe_reg[STAGES][31] ? $signed(dark_pipe_reg[STAGES]) + BIASD
                                        : $signed(dark_pipe_reg[STAGES]);
        dt  = dkb >>> F;
        res = $signed({23'b0, v10_reg}) - 35'(dt) + $signed({23'b0, cfg.dark_pedestal});
        if (cfg.bypass_dark) begin
            val_out = {2'b0, v10_reg};
        end else if (res < 35'sd0) begin
            val_out = '0;
        end else if (res > 35'sd16383) begin
            val_out = 14'd16383;
        end else begin
            val_out = res[13:0];
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg    <= p2_next;
            off2_reg  <= $signed(rd_reg[SEL_OFFSET]);
            step2_reg <= $signed(rd_reg[SEL_STEP]);
            saw2_reg  <= $signed(rd_reg[SEL_SAW]);
            o1_3_reg  <= o1_3_next;
            saw3_reg  <= saw2_reg;
            o1_4_reg  <= o1_3_reg;
            m4_reg    <= m4_next;
            k4_reg    <= k4_next;
            saw4_reg  <= saw3_reg;
            q5_reg    <= q5_next;
            o1_5_reg  <= o1_4_reg;
            k5_reg    <= k4_reg;
            s6_reg    <= s6_next;
            o64_6_reg <= o64_6_next;
            num7_reg  <= num7_next;
            mag8_reg  <= mag8_next;
            neg8_reg  <= a8[60];
            qd9_reg   <= prod9[RECIP_SHIFT +: 12];
            neg9_reg  <= neg8_reg;
            st10_reg  <= st10_next;
            v10_reg   <= v10_next;
            m_tdata_reg <= {6'b0, st10_reg, val_out};
        end
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[STAGES-1:1], pop_conv};
            m_tvalid_reg <= vld_reg[STAGES];
        end
    end

endmodule

// ----- rtl/core/adc_two_byte_sawtooth_correction.sv -----
// Two-byte pixel converter correction. Items on the s_ stream either write one
// coefficient (tuser 0) or convert one high/low byte pair (tuser 1); a
// conversion returns one item on the m_ stream, a write returns none. The block
// takes one item per clock while the output is not held. A conversion goes
// through the queue, the bank read and the arithmetic stages to m_tvalid. The
// rate is set by the six coefficient banks, each read once per conversion at
// the row of the pixel. After reset the coefficient store is swept row by row
// to gain 1.0 / all else 0, during which s_tready stays low; the APB registers
// can be written at any time the stream is idle.
module adc_two_byte_sawtooth_correction
    import adcsaw_pkg::*;
#(
    parameter int COLUMNS        = COLUMNS_DEF,
    parameter int NODES          = NODES_DEF,
    parameter int COEF_FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // node[1:0], column[6:2], full_frame[7], coef_select[10:8], coef_value[42:11],
    // high_byte[50:43], low_byte[58:51], low_gain[59], zero fill
    input  logic [63:0] s_tdata,
    // opcode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // value[13:0], status[17:14], zero fill
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int ROWS  = NODES * COLUMNS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int QW    = ROW_W + $bits(item_t);

    logic        bypass_reg;
    logic [11:0] ped_reg;
    cfg_t        cfg;

    logic             push, pop, q_full, q_empty, clearing;
    logic [ROW_W-1:0] push_row;
    item_t            push_item;
    logic [QW-1:0]    q_out;

    // Configuration registers
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg <= 1'b0;
            ped_reg    <= PEDESTAL_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_BYPASS) begin
                bypass_reg <= pwdata[0];
            end else begin
                ped_reg <= pwdata[11:0];
            end
        end
    end
    assign prdata = (paddr[2] == REG_PEDESTAL) ? {20'b0, ped_reg} : {31'b0, bypass_reg};
    assign cfg.bypass_dark   = bypass_reg;
    assign cfg.dark_pedestal = ped_reg;

    adcsaw_front #(
        .NODES  (NODES),
        .COLUMNS(COLUMNS),
        .ROW_W  (ROW_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (push),
        .push_row (push_row),
        .push_item(push_item)
    );

    adcsaw_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .din    ({push_row, push_item}),
        .pop    (pop),
        .dout   (q_out),
        .full   (q_full),
        .empty  (q_empty)
    );

    adcsaw_back #(
        .NODES         (NODES),
        .COLUMNS       (COLUMNS),
        .COEF_FRAC_BITS(COEF_FRAC_BITS),
        .ROW_W         (ROW_W)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_row   (q_out[QW-1 -: ROW_W]),
        .q_item  (item_t'(q_out[$bits(item_t)-1:0])),
        .q_pop   (pop),
        .clearing(clearing),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule
